[hw/rtl/brmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate tracker package
// Shared widths, command codes, sequencer states and the broadcast rate map.
// ----------------------------------------------------------------------------
package brmt_pkg;

    localparam int MAX_STATIONS_DEF = 64;
    localparam int MCS_LEVELS_DEF   = 12;

    localparam int CMD_W = 2;
    localparam int IDX_W = 6;
    localparam int MCS_W = 4;
    localparam int BC_W  = 3;

    localparam logic [MCS_W-1:0] MAP_TOP_MCS = 4'd11;
    localparam logic [BC_W-1:0]  BCAST_MAX   = 3'd5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ASSOC    = 2'd0,
        CMD_DISASSOC = 2'd1,
        CMD_RATE     = 2'd2,
        CMD_RESEND   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_APPLY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [BC_W-1:0]  broadcast_mcs;
        logic [MCS_W-1:0] min_station_mcs;
    } t_res;

    typedef struct packed {
        logic load;
        t_res res;
    } t_res_req;

    // Two station levels share one broadcast level; levels past the map top saturate.
    function automatic logic [BC_W-1:0] f_bcast_map(input logic [MCS_W-1:0] mcs);
        logic [BC_W-1:0] b;
        if (mcs > MAP_TOP_MCS) begin
            b = BCAST_MAX;
        end else begin
            b = mcs[BC_W:1];
        end
        return b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/brmt_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate tracker configuration channel
// Carries writes of the enable register.
// ----------------------------------------------------------------------------
interface brmt_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/brmt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate tracker event channel
// Carries one station event item per handshake.
// ----------------------------------------------------------------------------
interface brmt_in_if
    import brmt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] station_index;
    logic [MCS_W-1:0] mcs;
    logic             station_ready;

    modport source (output valid, output command, output station_index, output mcs,
                    output station_ready, input ready);
    modport sink (input valid, input command, input station_index, input mcs,
                  input station_ready, output ready);
endinterface
`default_nettype wire

[hw/rtl/brmt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate tracker result channel
// Carries one broadcast rate update item per handshake.
// ----------------------------------------------------------------------------
interface brmt_out_if
    import brmt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [BC_W-1:0]  broadcast_mcs;
    logic [MCS_W-1:0] min_station_mcs;

    modport source (output valid, output broadcast_mcs, output min_station_mcs,
                    input ready);
    modport sink (input valid, input broadcast_mcs, input min_station_mcs,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/brmt_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate tracker output stage
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module brmt_out_stage
    import brmt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_res_req  i_req,
    output logic           o_free,
    brmt_out_if.source     o_out
);

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.load && o_free) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load && o_free) begin
            r_res <= i_req.res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.broadcast_mcs   = r_res.broadcast_mcs;
    assign o_out.min_station_mcs = r_res.min_station_mcs;

endmodule
`default_nettype wire

[hw/rtl/broadcast_rate_min_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast rate minimum tracker
// Tracks the lowest station MCS and derives the broadcast MCS from it.
// ----------------------------------------------------------------------------
// Station events arrive on i_in: associate, disassociate, rate change and
// resend. Each accepted item yields zero or one result item on o_out, which
// carries the new broadcast MCS and the lowest station MCS. Results appear
// only when the broadcast MCS changes or on a resend while enabled.
// The i_cfg channel writes the enable bit; it is always ready.
// Station MCS values live in a synchronous memory with one write port and
// one read port, one entry per slot, with per-slot valid bits in flip-flops.
// An accepted item is evaluated; a resend then goes straight to the output
// register, and events that change the tracked minimum update it first. When
// the affected station held the minimum, or a rate change brings a station to
// or below it, the memory is first rescanned one entry per cycle; the scan
// stops early once a zero MCS is seen. One item is in work at a time.
// Reset clears the valid bits, the station count, the tracked minimum, the
// broadcast MCS and the enable bit. A stalled receiver holds the result in
// the output register; the next item is accepted meanwhile and waits only if
// it produces a result before the register is free.
// ----------------------------------------------------------------------------
module broadcast_rate_min_tracker
    import brmt_pkg::*;
#(
    parameter int MAX_STATIONS = MAX_STATIONS_DEF,
    parameter int MCS_LEVELS   = MCS_LEVELS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    brmt_cfg_if.sink    i_cfg,
    brmt_in_if.sink     i_in,
    brmt_out_if.source  o_out
);

    localparam int DEPTH = (MAX_STATIONS < 2**IDX_W) ? MAX_STATIONS : 2**IDX_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [MCS_W-1:0] MAX_MCS = MCS_W'(MCS_LEVELS - 1);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [AW-1:0]     r_addr, n_addr;
    logic [MCS_W-1:0]  r_mcs, n_mcs;
    logic              r_sready, n_sready;
    logic              r_in_range, n_in_range;
    logic              r_enable;
    logic [DEPTH-1:0]  r_valid, n_valid;
    logic [CW-1:0]     r_count, n_count;
    logic [MCS_W-1:0]  r_min, n_min;
    logic [BC_W-1:0]   r_cur, n_cur;
    logic [MCS_W-1:0]  r_cand, n_cand;
    logic [CW-1:0]     r_scan_cnt, n_scan_cnt;
    logic              r_scan_pend, n_scan_pend;
    logic              r_scan_vld, n_scan_vld;
    logic [MCS_W-1:0]  r_scan_min, n_scan_min;
    t_res              r_res, n_res;

    logic [MCS_W-1:0]  r_mem [DEPTH];
    logic [MCS_W-1:0]  r_rd_data;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic              slot_vld;
    logic [BC_W-1:0]   new_bcast;
    logic              out_free;
    t_res_req          res_req;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_enable <= i_cfg.data;
        end
    end

    assign rd_addr = (r_state == S_SCAN) ? r_scan_cnt[AW-1:0] : i_in.station_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= r_mcs;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_min       <= '0;
            r_cur       <= '0;
            r_scan_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_min       <= n_min;
            r_cur       <= n_cur;
            r_scan_pend <= n_scan_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_mcs      <= n_mcs;
        r_sready   <= n_sready;
        r_in_range <= n_in_range;
        r_cand     <= n_cand;
        r_scan_cnt <= n_scan_cnt;
        r_scan_vld <= n_scan_vld;
        r_scan_min <= n_scan_min;
        r_res      <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_mcs       = r_mcs;
        n_sready    = r_sready;
        n_in_range  = r_in_range;
        n_valid     = r_valid;
        n_count     = r_count;
        n_min       = r_min;
        n_cur       = r_cur;
        n_cand      = r_cand;
        n_scan_cnt  = r_scan_cnt;
        n_scan_pend = 1'b0;
        n_scan_vld  = r_scan_vld;
        n_scan_min  = r_scan_min;
        n_res       = r_res;
        mem_we      = 1'b0;
        slot_vld    = r_valid[r_addr];
        new_bcast   = f_bcast_map(r_cand);
        res_req     = '{load: 1'b0, res: r_res};

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd      = t_cmd'(i_in.command);
                    n_addr     = i_in.station_index[AW-1:0];
                    n_mcs      = (i_in.mcs > MAX_MCS) ? MAX_MCS : i_in.mcs;
                    n_sready   = i_in.station_ready;
                    n_in_range = int'(i_in.station_index) < MAX_STATIONS;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state    = S_IDLE;
                n_scan_cnt = '0;
                n_scan_min = MAX_MCS;
                unique case (r_cmd)
                    CMD_RESEND: begin
                        if (r_enable) begin
                            n_res   = '{broadcast_mcs: r_cur, min_station_mcs: r_min};
                            n_state = S_EMIT;
                        end
                    end
                    CMD_ASSOC: begin
                        if (r_in_range) begin
                            mem_we          = 1'b1;
                            n_valid[r_addr] = 1'b1;
                            if (!slot_vld) begin
                                n_count = r_count + CW'(1);
                            end
                            if (r_enable && (n_count == CW'(1) || r_mcs < r_min)) begin
                                n_cand  = r_mcs;
                                n_state = S_APPLY;
                            end
                        end
                    end
                    CMD_DISASSOC: begin
                        if (r_in_range && slot_vld) begin
                            n_valid[r_addr] = 1'b0;
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                            if (r_enable) begin
                                if (n_count == '0) begin
                                    n_cand  = '0;
                                    n_state = S_APPLY;
                                end else if (!(r_rd_data > r_min)) begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                    end
                    CMD_RATE: begin
                        if (r_in_range && slot_vld) begin
                            mem_we = 1'b1;
                            if (r_enable && r_sready) begin
                                if (r_count == CW'(1)) begin
                                    n_cand  = r_mcs;
                                    n_state = S_APPLY;
                                end else if (!(r_rd_data > r_min && r_mcs > r_min)) begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (r_scan_cnt < CW'(DEPTH)) begin
                    n_scan_cnt  = r_scan_cnt + CW'(1);
                    n_scan_pend = 1'b1;
                    n_scan_vld  = r_valid[r_scan_cnt[AW-1:0]];
                end
                if (r_scan_pend && r_scan_vld && r_rd_data < r_scan_min) begin
                    n_scan_min = r_rd_data;
                end
                if (r_scan_min == '0 || (!r_scan_pend && r_scan_cnt == CW'(DEPTH))) begin
                    n_scan_pend = 1'b0;
                    n_cand      = r_scan_min;
                    n_state     = S_APPLY;
                end
            end
            S_APPLY: begin
                n_min   = r_cand;
                n_state = S_IDLE;
                if (new_bcast != r_cur) begin
                    n_cur   = new_bcast;
                    n_res   = '{broadcast_mcs: new_bcast, min_station_mcs: r_cand};
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                res_req.load = 1'b1;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    brmt_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (res_req),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_bcast_follows_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur == f_bcast_map(r_min))
        else $error("Broadcast MCS does not match the tracked minimum.");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("Station count differs from the number of valid slots.");

    a_min_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= MAX_MCS)
        else $error("Tracked minimum exceeds the top MCS level.");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !out_free) |=> (r_state == S_EMIT))
        else $error("Pending result item left before the output stage took it.");
`endif

endmodule
`default_nettype wire

[bench/broadcast_rate_min_tracker_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast rate tracker result checker
// Watches the enable, event and result channels of the tracker. It keeps its
// own station table and predicts every broadcast rate update. Each result item
// is compared field by field with the oldest pending update.
// ----------------------------------------------------------------------------
module broadcast_rate_min_tracker_chk
    import brmt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    brmt_cfg_if       i_cfg,
    brmt_in_if        i_in,
    brmt_out_if       i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_updates
);

    localparam int               N_SLOTS = MAX_STATIONS_DEF;
    localparam logic [MCS_W-1:0] TOP_MCS = MCS_W'(MCS_LEVELS_DEF - 1);

    logic [MCS_W-1:0] slot_mcs [N_SLOTS];
    bit               slot_used [N_SLOTS];
    int unsigned      used_count;
    logic [MCS_W-1:0] low_mcs;
    logic [BC_W-1:0]  bcast_level;
    bit               track_en;
    t_res             expected_updates [$];
    int               n_errors = 0;
    int               n_updates = 0;

    function automatic logic [BC_W-1:0] halve_rate(input logic [MCS_W-1:0] m);
        return (m > TOP_MCS) ? BC_W'(TOP_MCS >> 1) : BC_W'(m >> 1);
    endfunction

    function automatic logic [MCS_W-1:0] lowest_used();
        logic [MCS_W-1:0] m;
        m = TOP_MCS;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (slot_used[i] && slot_mcs[i] < m) begin
                m = slot_mcs[i];
            end
        end
        return m;
    endfunction

    function automatic void settle_min(input logic [MCS_W-1:0] m);
        t_res r;
        low_mcs = m;
        if (halve_rate(m) != bcast_level) begin
            bcast_level = halve_rate(m);
            r.broadcast_mcs = bcast_level;
            r.min_station_mcs = low_mcs;
            expected_updates.push_back(r);
        end
    endfunction

    function automatic void track_event(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                                        input logic [MCS_W-1:0] raw_mcs, input logic rdy);
        logic [MCS_W-1:0] m;
        logic [MCS_W-1:0] prev;
        t_res             r;
        m = (raw_mcs > TOP_MCS) ? TOP_MCS : raw_mcs;
        case (cmd)
            CMD_RESEND: begin
                if (track_en) begin
                    r.broadcast_mcs = bcast_level;
                    r.min_station_mcs = low_mcs;
                    expected_updates.push_back(r);
                end
            end
            CMD_ASSOC: begin
                if (!slot_used[idx]) begin
                    slot_used[idx] = 1'b1;
                    used_count++;
                end
                slot_mcs[idx] = m;
                if (track_en && (used_count == 1 || m < low_mcs)) begin
                    settle_min(m);
                end
            end
            CMD_DISASSOC: begin
                if (slot_used[idx]) begin
                    prev = slot_mcs[idx];
                    slot_used[idx] = 1'b0;
                    used_count--;
                    if (track_en) begin
                        if (used_count == 0) begin
                            settle_min('0);
                        end else if (prev <= low_mcs) begin
                            settle_min(lowest_used());
                        end
                    end
                end
            end
            default: begin
                // A rate change only recomputes once the station is fully added.
                if (slot_used[idx]) begin
                    prev = slot_mcs[idx];
                    slot_mcs[idx] = m;
                    if (track_en && rdy) begin
                        if (used_count == 1) begin
                            settle_min(m);
                        end else if (prev <= low_mcs || m <= low_mcs) begin
                            settle_min(lowest_used());
                        end
                    end
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < N_SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_mcs[i] = '0;
            end
            used_count = 0;
            low_mcs = '0;
            bcast_level = '0;
            track_en = 1'b0;
            expected_updates.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                n_updates++;
                if (expected_updates.size() == 0) begin
                    $error("unexpected result item: broadcast_mcs %0d, min_station_mcs %0d",
                           i_out.broadcast_mcs, i_out.min_station_mcs);
                    n_errors++;
                end else begin
                    want = expected_updates.pop_front();
                    if (i_out.broadcast_mcs !== want.broadcast_mcs) begin
                        $error("broadcast_mcs: expected %0d, actual %0d",
                               want.broadcast_mcs, i_out.broadcast_mcs);
                        n_errors++;
                    end
                    if (i_out.min_station_mcs !== want.min_station_mcs) begin
                        $error("min_station_mcs: expected %0d, actual %0d",
                               want.min_station_mcs, i_out.min_station_mcs);
                        n_errors++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                track_en = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                track_event(t_cmd'(i_in.command), i_in.station_index, i_in.mcs,
                            i_in.station_ready);
            end
        end
        o_errors <= n_errors;
        o_pending <= expected_updates.size();
        o_updates <= n_updates;
    end

endmodule

[bench/broadcast_rate_min_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast rate minimum tracker testbench
// Drives station events and enable writes into the tracker with random gaps
// and result back-pressure, and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module broadcast_rate_min_tracker_tb;
    import brmt_pkg::*;

    localparam int SETTLE_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n;
    logic ev_taken;
    logic cfg_taken;
    bit   calm;
    int   errors;
    int   pending;
    int   updates;
    int   n_items;
    int   n_cfg;

    brmt_cfg_if cfg_ch ();
    brmt_in_if  ev_ch ();
    brmt_out_if upd_ch ();

    broadcast_rate_min_tracker dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (ev_ch),
        .o_out   (upd_ch)
    );

    broadcast_rate_min_tracker_chk u_chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg     (cfg_ch),
        .i_in      (ev_ch),
        .i_out     (upd_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_updates (updates)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        ev_taken <= ev_ch.valid && ev_ch.ready;
        cfg_taken <= cfg_ch.valid && cfg_ch.ready;
    end

    always @(negedge clk) begin
        upd_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    task automatic send_event(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                              input logic [MCS_W-1:0] m, input logic rdy);
        calm = (n_items >= 700 && n_items < 1000);
        while (!calm && $urandom_range(0, 99) < 37) begin
            ev_ch.valid = 1'b0;
            @(negedge clk);
        end
        ev_ch.valid = 1'b1;
        ev_ch.command = cmd;
        ev_ch.station_index = idx;
        ev_ch.mcs = m;
        ev_ch.station_ready = rdy;
        do @(negedge clk); while (!ev_taken);
        n_items++;
    endtask

    task automatic write_enable(input logic en);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = en;
        do @(negedge clk); while (!cfg_taken);
        cfg_ch.valid = 1'b0;
        n_cfg++;
    endtask

    // Every pending update has to arrive; the pause then covers a full rescan.
    task automatic drain();
        ev_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_event(input int pool, input int base);
        t_cmd             cmd;
        int               pick;
        logic [IDX_W-1:0] idx;
        logic [MCS_W-1:0] m;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            cmd = CMD_ASSOC;
        end else if (pick < 60) begin
            cmd = CMD_DISASSOC;
        end else if (pick < 90) begin
            cmd = CMD_RATE;
        end else begin
            cmd = CMD_RESEND;
        end
        idx = IDX_W'((base + $urandom_range(0, pool - 1)) % MAX_STATIONS_DEF);
        if ($urandom_range(0, 9) == 0) begin
            m = MCS_W'($urandom_range(12, 15));
        end else begin
            m = MCS_W'($urandom_range(0, 11));
        end
        send_event(cmd, idx, m, $urandom_range(0, 99) < 85);
    endtask

    task automatic run_phase(input logic en, input int len, input int pool);
        int base;
        base = $urandom_range(0, MAX_STATIONS_DEF - 1);
        write_enable(en);
        repeat (len) random_event(pool, base);
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        calm = 1'b0;
        n_items = 0;
        n_cfg = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 1'b0;
        ev_ch.valid = 1'b0;
        ev_ch.command = CMD_ASSOC;
        ev_ch.station_index = '0;
        ev_ch.mcs = '0;
        ev_ch.station_ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_enable(1'b1);
        send_event(CMD_ASSOC, 6'd5, 4'd7, 1'b1);
        send_event(CMD_ASSOC, 6'd9, 4'd15, 1'b1);
        send_event(CMD_ASSOC, 6'd62, 4'd3, 1'b1);
        send_event(CMD_RESEND, 6'd0, 4'd0, 1'b0);
        send_event(CMD_RATE, 6'd5, 4'd6, 1'b1);
        send_event(CMD_RATE, 6'd62, 4'd8, 1'b1);
        send_event(CMD_ASSOC, 6'd0, 4'd0, 1'b1);
        send_event(CMD_ASSOC, 6'd33, 4'd0, 1'b1);
        send_event(CMD_DISASSOC, 6'd0, 4'd0, 1'b1);
        send_event(CMD_DISASSOC, 6'd33, 4'd0, 1'b1);
        send_event(CMD_RATE, 6'd62, 4'd12, 1'b0);
        send_event(CMD_RATE, 6'd62, 4'd2, 1'b1);
        send_event(CMD_DISASSOC, 6'd40, 4'd0, 1'b1);
        send_event(CMD_RATE, 6'd41, 4'd4, 1'b1);
        send_event(CMD_ASSOC, 6'd5, 4'd9, 1'b1);
        send_event(CMD_RESEND, 6'd63, 4'd15, 1'b1);
        send_event(CMD_DISASSOC, 6'd62, 4'd0, 1'b1);
        send_event(CMD_DISASSOC, 6'd9, 4'd0, 1'b1);
        send_event(CMD_DISASSOC, 6'd5, 4'd0, 1'b1);
        send_event(CMD_ASSOC, 6'd63, 4'd11, 1'b1);
        send_event(CMD_RESEND, 6'd21, 4'd5, 1'b1);
        send_event(CMD_DISASSOC, 6'd63, 4'd0, 1'b1);
        drain();

        run_phase(1'b1, 450, 8);
        run_phase(1'b0, 150, 64);
        run_phase(1'b1, 550, 64);
        run_phase(1'b0, 150, 4);
        run_phase(1'b1, 580, 16);

        $display("Sent %0d station event items, checked %0d result items, %0d enable writes.",
                 n_items, updates, n_cfg);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout: %0d items sent, %0d updates still pending.", n_items, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
